// ===== hdl/wpet_pkg.sv =====
// Package for the wheel position error tracker.
// Holds field widths, codes, fixed-point scaling constants and the per-wheel command struct.
// No dependencies; every other file imports this one.
package wpet_pkg;

   // field widths
   localparam int COUNT_WIDTH    = 13;
   localparam int DIFF_WIDTH     = COUNT_WIDTH + 1;
   localparam int ANGLE_WIDTH    = 16;
   localparam int ERROR_WIDTH    = 32;
   localparam int TURNS_WIDTH    = 32;
   localparam int DEADBAND_WIDTH = 16;

   // encoder geometry
   localparam logic [DIFF_WIDTH-1:0] COUNTS_PER_REV = DIFF_WIDTH'(8192);
   localparam logic signed [DIFF_WIDTH-1:0] WRAP_LIMIT = DIFF_WIDTH'(6000);

   // deadband after reset
   localparam logic [DEADBAND_WIDTH-1:0] DEADBAND_RESET = DEADBAND_WIDTH'(100);

   // angle scaling: 819.1 counts per unit = 8191 / 10, 8191 = 2^13 - 1
   localparam int SCALE_SHIFT = 13;
   localparam int DIV10_SHIFT = 35;
   localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;

   // input codes
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_ANGLE  = 1'b1;
   localparam logic WHEEL_0     = 1'b0;
   localparam logic WHEEL_1     = 1'b1;

   typedef logic [COUNT_WIDTH-1:0]           count_type;
   typedef logic signed [ANGLE_WIDTH-1:0]    angle_type;
   typedef logic signed [ERROR_WIDTH-1:0]    error_type;
   typedef logic [TURNS_WIDTH-1:0]           turns_type;
   typedef logic [DEADBAND_WIDTH-1:0]        deadband_type;

   // per-wheel update request, already gated by the pipeline advance
   typedef struct packed {
      logic      angle_hit;
      logic      sample;
      count_type count_now;
      count_type count_prev;
      logic      run_enable;
   } wheel_cmd_type;

endpackage

// ===== hdl/wpet_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on wpet_pkg for payload types.
interface wpet_req_if import wpet_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      mode;
   logic      wheel;
   angle_type target_angle;
   count_type count_now_w0;
   count_type count_prev_w0;
   count_type count_now_w1;
   count_type count_prev_w1;
   logic      run_enable;

   modport source (
      output valid, mode, wheel, target_angle, count_now_w0, count_prev_w0,
             count_now_w1, count_prev_w1, run_enable,
      input  ready
   );
   modport sink (
      input  valid, mode, wheel, target_angle, count_now_w0, count_prev_w0,
             count_now_w1, count_prev_w1, run_enable,
      output ready
   );
endinterface

interface wpet_rsp_if import wpet_pkg::*; ();
   logic      valid;
   logic      ready;
   error_type error_w0;
   error_type error_w1;
   logic      moving_w0;
   logic      moving_w1;
   turns_type turns_w0;
   turns_type turns_w1;

   modport source (
      output valid, error_w0, error_w1, moving_w0, moving_w1, turns_w0, turns_w1,
      input  ready
   );
   modport sink (
      input  valid, error_w0, error_w1, moving_w0, moving_w1, turns_w0, turns_w1,
      output ready
   );
endinterface

// ===== hdl/wheel_position_error_tracker_core.sv =====
// Wheel position error tracker, top level: input register, two wheel trackers, deadband CSR.
// The wheel update is a single pass from the input register into the wheel state registers.
// Throughput: one beat per cycle while the output is not back-pressured.
// Output back-pressure stalls the input register; req ready drops only when both are full.
// Reset (synchronous, active high) clears errors, turns, flags, angles, valids; deadband = 100.
// Depends on wpet_pkg, wpet_if, wpet_wheel.
module wheel_position_error_tracker_core import wpet_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   wpet_req_if.sink     req_if,
   wpet_rsp_if.source   rsp_if,
   input  logic         csr_write_enable,
   input  deadband_type csr_write_data
);

   logic         in_valid_ff, in_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   deadband_type deadband_ff, deadband_in;

   logic      in_mode_ff;
   logic      in_wheel_ff;
   angle_type in_angle_ff;
   count_type in_now_w0_ff;
   count_type in_prev_w0_ff;
   count_type in_now_w1_ff;
   count_type in_prev_w1_ff;
   logic      in_run_ff;

   logic          req_fire;
   logic          advance;
   logic          is_angle;
   wheel_cmd_type cmd_w0;
   wheel_cmd_type cmd_w1;

   // handshake: input stage moves when the result slot is free or being drained
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_fire      = req_if.valid && req_if.ready;
   assign in_valid_in   = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_if.ready);
   assign deadband_in   = csr_write_enable ? csr_write_data : deadband_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         deadband_ff  <= DEADBAND_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         deadband_ff  <= deadband_in;
      end
   end

   // input beat register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff    <= req_if.mode;
         in_wheel_ff   <= req_if.wheel;
         in_angle_ff   <= req_if.target_angle;
         in_now_w0_ff  <= req_if.count_now_w0;
         in_prev_w0_ff <= req_if.count_prev_w0;
         in_now_w1_ff  <= req_if.count_now_w1;
         in_prev_w1_ff <= req_if.count_prev_w1;
         in_run_ff     <= req_if.run_enable;
      end
   end

   // per-wheel commands
   assign is_angle = (in_mode_ff == MODE_ANGLE);

   always_comb begin
      cmd_w0.angle_hit  = advance && is_angle && (in_wheel_ff == WHEEL_0);
      cmd_w0.sample     = advance && (in_mode_ff == MODE_SAMPLE);
      cmd_w0.count_now  = in_now_w0_ff;
      cmd_w0.count_prev = in_prev_w0_ff;
      cmd_w0.run_enable = in_run_ff;
      cmd_w1.angle_hit  = advance && is_angle && (in_wheel_ff == WHEEL_1);
      cmd_w1.sample     = advance && (in_mode_ff == MODE_SAMPLE);
      cmd_w1.count_now  = in_now_w1_ff;
      cmd_w1.count_prev = in_prev_w1_ff;
      cmd_w1.run_enable = in_run_ff;
   end

   wpet_wheel u_wheel0 (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd_w0),
      .target_angle (in_angle_ff),
      .deadband     (deadband_ff),
      .error_out    (rsp_if.error_w0),
      .moving_out   (rsp_if.moving_w0),
      .turns_out    (rsp_if.turns_w0)
   );

   wpet_wheel u_wheel1 (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd_w1),
      .target_angle (in_angle_ff),
      .deadband     (deadband_ff),
      .error_out    (rsp_if.error_w1),
      .moving_out   (rsp_if.moving_w1),
      .turns_out    (rsp_if.turns_w1)
   );

   assign rsp_if.valid = rsp_valid_ff;

   // angle beat for wheel 0 leaves wheel 1 alone
   a_angle_isolates_w1 : assert property (@(posedge clock) disable iff (reset)
      cmd_w0.angle_hit |=> $stable(rsp_if.error_w1) && $stable(rsp_if.moving_w1))
      else $error("angle beat for wheel 0 disturbed wheel 1");

   // angle beats never touch turn counts or moving flags
   a_angle_keeps_turns : assert property (@(posedge clock) disable iff (reset)
      (advance && is_angle) |=> $stable(rsp_if.turns_w0) && $stable(rsp_if.turns_w1)
                                && $stable(rsp_if.moving_w0) && $stable(rsp_if.moving_w1))
      else $error("angle beat changed turns or moving flags");

   // a sample with run disabled leaves both wheels cleared
   a_run_off_clears : assert property (@(posedge clock) disable iff (reset)
      (advance && !is_angle && !in_run_ff) |=>
         (rsp_if.error_w0 == '0) && (rsp_if.error_w1 == '0)
         && !rsp_if.moving_w0 && !rsp_if.moving_w1)
      else $error("run disable did not clear tracking state");

endmodule

// ===== hdl/wpet_scale.sv =====
// Angle step to position error: trunc((target - stored) * 8191 / 10) toward zero.
// Depends on wpet_pkg. Shift-subtract for *8191, reciprocal multiply for /10.
module wpet_scale import wpet_pkg::*; (
   input  angle_type target_angle,
   input  angle_type stored_angle,
   output error_type scaled_error
);

   localparam int STEP_WIDTH = ANGLE_WIDTH + 1;
   localparam int PROD_WIDTH = STEP_WIDTH + SCALE_SHIFT;
   localparam int FULL_WIDTH = PROD_WIDTH + 32;
   localparam int QUO_WIDTH  = FULL_WIDTH - DIV10_SHIFT;

   logic signed [STEP_WIDTH-1:0] step;
   logic [STEP_WIDTH-1:0]        step_mag;
   logic [PROD_WIDTH-1:0]        prod;
   logic [FULL_WIDTH-1:0]        full;
   logic [ERROR_WIDTH-1:0]       quo;

   // signed step and its magnitude
   assign step     = {target_angle[ANGLE_WIDTH-1], target_angle}
                   - {stored_angle[ANGLE_WIDTH-1], stored_angle};
   assign step_mag = step[STEP_WIDTH-1] ? (~step + STEP_WIDTH'(1)) : step;

   // |step| * (2^13 - 1)
   assign prod = {step_mag, {SCALE_SHIFT{1'b0}}} - PROD_WIDTH'(step_mag);

   // floor(prod / 10), exact for prod below 2^32
   assign full = FULL_WIDTH'(prod) * FULL_WIDTH'(DIV10_MAGIC);
   assign quo  = ERROR_WIDTH'(full[FULL_WIDTH-1:DIV10_SHIFT]);

   // restore the sign (truncation toward zero)
   assign scaled_error = step[STEP_WIDTH-1] ? error_type'(~quo + ERROR_WIDTH'(1))
                                            : error_type'(quo);

   // quotient fits well inside the error word
   if (QUO_WIDTH > ERROR_WIDTH) begin : g_width_check
      $error("wpet_scale: quotient wider than error word");
   end

endmodule

// ===== hdl/wpet_wheel.sv =====
// Tracking state and update logic for one wheel: error, turn count, moving flag, angle.
// Depends on wpet_pkg and wpet_scale. State registers double as the result payload.
module wpet_wheel import wpet_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  wheel_cmd_type cmd,
   input  angle_type     target_angle,
   input  deadband_type  deadband,
   output error_type     error_out,
   output logic          moving_out,
   output turns_type     turns_out
);

   localparam int CMP_WIDTH = ERROR_WIDTH + 1;

   error_type error_ff, error_in;
   turns_type turns_ff, turns_in;
   logic      moving_ff, moving_in;
   angle_type angle_ff, angle_in;

   logic signed [DIFF_WIDTH-1:0] diff;
   logic signed [DIFF_WIDTH-1:0] delta;
   logic                         wrap_fwd;
   logic                         wrap_back;
   error_type                    error_sum;
   error_type                    scaled_error;
   logic signed [CMP_WIDTH-1:0]  sum_ext;
   logic signed [CMP_WIDTH-1:0]  db_pos;
   logic signed [CMP_WIDTH-1:0]  db_neg;
   logic                         flag_set;
   logic                         in_band;

   wpet_scale u_scale (
      .target_angle (target_angle),
      .stored_angle (angle_ff),
      .scaled_error (scaled_error)
   );

   // count delta, unwrapped across the rollover
   assign diff      = {1'b0, cmd.count_now} - {1'b0, cmd.count_prev};
   assign wrap_fwd  = diff < -WRAP_LIMIT;
   assign wrap_back = diff > WRAP_LIMIT;

   always_comb begin
      delta = diff;
      if (wrap_fwd) begin
         delta = diff + COUNTS_PER_REV;
      end else if (wrap_back) begin
         delta = diff - COUNTS_PER_REV;
      end
   end

   assign error_sum = error_ff + {{(ERROR_WIDTH-DIFF_WIDTH){delta[DIFF_WIDTH-1]}}, delta};

   // deadband compare on the updated error
   assign sum_ext  = {error_sum[ERROR_WIDTH-1], error_sum};
   assign db_pos   = {{(CMP_WIDTH-DEADBAND_WIDTH){1'b0}}, deadband};
   assign db_neg   = -db_pos;
   assign flag_set = moving_ff || (sum_ext <= db_neg) || (sum_ext >= db_pos);
   assign in_band  = (sum_ext >= db_neg) && (sum_ext <= db_pos);

   // next state
   always_comb begin
      error_in  = error_ff;
      turns_in  = turns_ff;
      moving_in = moving_ff;
      angle_in  = angle_ff;
      if (cmd.angle_hit) begin
         if (target_angle != angle_ff) begin
            error_in = scaled_error;
            angle_in = target_angle;
         end
      end else if (cmd.sample) begin
         if (wrap_fwd) begin
            turns_in = turns_ff + TURNS_WIDTH'(1);
         end else if (wrap_back) begin
            turns_in = turns_ff - TURNS_WIDTH'(1);
         end
         if (cmd.run_enable) begin
            error_in  = error_sum;
            moving_in = flag_set && !in_band;
            if (flag_set && in_band) begin
               angle_in = '0;
            end
         end else begin
            error_in  = '0;
            moving_in = 1'b0;
            angle_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_ff  <= '0;
         turns_ff  <= '0;
         moving_ff <= 1'b0;
         angle_ff  <= '0;
      end else begin
         error_ff  <= error_in;
         turns_ff  <= turns_in;
         moving_ff <= moving_in;
         angle_ff  <= angle_in;
      end
   end

   assign error_out  = error_ff;
   assign moving_out = moving_ff;
   assign turns_out  = turns_ff;

endmodule
